[sv/periodic_task_scheduler_assert.svh]
// ----------------------------------------------------------------------------
// periodic_task_scheduler_assert.svh
// Assertion macros used by the checker file of the task scheduler.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_SCHEDULER_ASSERT_SVH

// Concurrent assertion that is switched off while reset is held.
`define PTS_ASSERT_RUN(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent assertion that is checked on every edge, reset included.
`define PTS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types, codes and field layout of the periodic task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

    // Default sizes of the slot table.
    localparam int MAX_SLOTS_DEF = 8;
    localparam int TIME_BITS_DEF = 32;

    // Field widths of the stream words.
    localparam int TIME_FIELD_W = 32;
    localparam int SLOT_W       = 3;
    localparam int KIND_W       = 2;

    // Input word layout: now_time, period, first_time from the lowest bit up.
    localparam int NOW_LSB    = 0;
    localparam int PERIOD_LSB = NOW_LSB + TIME_FIELD_W;
    localparam int FIRST_LSB  = PERIOD_LSB + TIME_FIELD_W;
    localparam int S_TDATA_W  = FIRST_LSB + TIME_FIELD_W;
    localparam int S_TUSER_W  = 1;

    // Result word: slot_index padded to a whole byte.
    localparam int M_TDATA_W = ((SLOT_W + 7) / 8) * 8;

    // Command carried in the input tuser.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ADD  = 1'b1;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_FIRED = 2'd0,
        KIND_ADDED = 2'd1,
        KIND_FULL  = 2'd2,
        KIND_IDLE  = 2'd3
    } kind_t;

    // One result word as held in the pending and output registers.
    typedef struct packed {
        kind_t             kind;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

[sv/periodic_task_scheduler.sv]
// ----------------------------------------------------------------------------
// periodic_task_scheduler
// Table of periodic task slots that reports which tasks are due on a tick.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one command word per handshake. tuser selects a time
//   tick or an add; an add stores period and first_time in the next free slot
//   and answers with one word (added, or rejected when the table is full).
//   A tick carries now_time; every filled slot whose elapsed time has reached
//   its interval gives one fired word, in ascending slot order, and a tick
//   with nothing due gives one idle word. tlast marks the final word of a
//   command.
//   Flow: the answer to an add, or to a tick on an empty table, passes
//   through the pending register and then the output register. A tick walks
//   the slot memory one slot per cycle while it does not stall; the read of
//   the next slot overlaps the check of the current one and the write back
//   of its stamp when it is due. A fired word waits in the pending register
//   for the next fired word or the end of the walk. A new command is taken
//   as soon as the walk is over and the pending word has moved to the output
//   register, even while that word is still waiting.
//   Reset empties the table (the slot memory itself is not cleared, only the
//   fill count) and drops any word in flight. When the receiver stalls, the
//   walk halts on the next due slot until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_scheduler #(
    parameter int MAX_SLOTS = pts_pkg::MAX_SLOTS_DEF,
    parameter int TIME_BITS = pts_pkg::TIME_BITS_DEF
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    // Command channel.
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [pts_pkg::S_TDATA_W-1:0]     s_tdata,  // now_time, period, first_time
    input  wire  [pts_pkg::S_TUSER_W-1:0]     s_tuser,  // cmd
    // Result channel.
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [pts_pkg::M_TDATA_W-1:0]     m_tdata,  // slot_index, zero padding
    output logic [pts_pkg::KIND_W-1:0]        m_tuser,  // kind
    output logic                              m_tlast   // last
);

    import pts_pkg::*;

    localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int WORD_W = 2 * TIME_BITS;
    localparam logic [CNT_W-1:0] SLOTS_FULL = CNT_W'(MAX_SLOTS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    // Control registers.
    state_t              state_reg,      state_next;
    logic [CNT_W-1:0]    filled_reg,     filled_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                pend_done_reg,  pend_done_next;
    logic                out_valid_reg,  out_valid_next;

    // Payload registers.
    logic [IDX_W-1:0]    chk_idx_reg,    chk_idx_next;
    logic [TIME_BITS-1:0] now_reg,       now_next;
    result_t             pend_reg,       pend_next;
    result_t             out_reg,        out_next;

    // Slot memory ports; a word is {interval, stamp}.
    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [WORD_W-1:0]   ram_wr_data;
    logic                ram_rd_en;
    logic [IDX_W-1:0]    ram_rd_addr;
    logic [WORD_W-1:0]   ram_rd_data;

    logic                 cmd_in;
    logic [TIME_BITS-1:0] now_in;
    logic [TIME_BITS-1:0] period_in;
    logic [TIME_BITS-1:0] first_in;
    logic [TIME_BITS-1:0] cur_interval;
    logic [TIME_BITS-1:0] cur_stamp;
    logic [TIME_BITS-1:0] elapsed;
    logic                 fire;
    logic                 chk_final;
    logic                 out_free;
    logic                 stall;
    logic                 accept;

    pts_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Input field decode; times are taken modulo 2^TIME_BITS.
    assign cmd_in    = s_tuser[0];
    assign now_in    = TIME_BITS'(s_tdata[NOW_LSB +: TIME_FIELD_W]);
    assign period_in = TIME_BITS'(s_tdata[PERIOD_LSB +: TIME_FIELD_W]);
    assign first_in  = TIME_BITS'(s_tdata[FIRST_LSB +: TIME_FIELD_W]);

    // Due check on the slot word last read from the slot memory.
    assign cur_interval = ram_rd_data[WORD_W-1:TIME_BITS];
    assign cur_stamp    = ram_rd_data[TIME_BITS-1:0];
    assign elapsed      = now_reg - cur_stamp;
    assign fire         = (elapsed >= cur_interval);
    assign chk_final    = ((CNT_W'(chk_idx_reg) + CNT_W'(1)) == filled_reg);

    // Handshake terms.
    assign out_free = !out_valid_reg || m_tready;
    assign stall    = (state_reg == ST_SCAN) && fire && pend_valid_reg && !out_free;
    assign s_tready = (state_reg == ST_IDLE) && !pend_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // Sequencer, pending word and output register.
    always_comb begin
        state_next      = state_reg;
        filled_next     = filled_reg;
        pend_valid_next = pend_valid_reg;
        pend_done_next  = pend_done_reg;
        out_valid_next  = out_valid_reg;
        chk_idx_next    = chk_idx_reg;
        now_next        = now_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = chk_idx_reg;
        ram_wr_data     = {cur_interval, now_reg};
        ram_rd_en       = 1'b0;
        ram_rd_addr     = chk_idx_reg + IDX_W'(1);

        // The receiver takes the output word.
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        // A finished pending word moves to the output register.
        if (pend_valid_reg && pend_done_reg && out_free) begin
            out_next        = pend_reg;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (cmd_in == CMD_ADD) begin
                        if (filled_reg != SLOTS_FULL) begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = IDX_W'(filled_reg);
                            ram_wr_data = {period_in, first_in};
                            pend_next   = '{kind: KIND_ADDED, slot: SLOT_W'(filled_reg),
                                            last: 1'b1};
                            filled_next = filled_reg + CNT_W'(1);
                        end else begin
                            pend_next = '{kind: KIND_FULL, slot: '0, last: 1'b1};
                        end
                        pend_valid_next = 1'b1;
                        pend_done_next  = 1'b1;
                    end else begin
                        now_next = now_in;
                        if (filled_reg == '0) begin
                            pend_next       = '{kind: KIND_IDLE, slot: '0, last: 1'b1};
                            pend_valid_next = 1'b1;
                            pend_done_next  = 1'b1;
                        end else begin
                            ram_rd_en    = 1'b1;
                            ram_rd_addr  = '0;
                            chk_idx_next = '0;
                            state_next   = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    if (fire) begin
                        // Stamp the slot and hold its word until the next one
                        // shows whether it is the final word of the tick.
                        ram_wr_en = 1'b1;
                        if (pend_valid_reg) begin
                            out_next       = pend_reg;
                            out_valid_next = 1'b1;
                        end
                        pend_next = '{kind: KIND_FIRED, slot: SLOT_W'(chk_idx_reg),
                                      last: chk_final};
                        pend_valid_next = 1'b1;
                        pend_done_next  = chk_final;
                    end else if (chk_final) begin
                        if (pend_valid_reg) begin
                            pend_next.last = 1'b1;
                        end else begin
                            pend_next       = '{kind: KIND_IDLE, slot: '0, last: 1'b1};
                            pend_valid_next = 1'b1;
                        end
                        pend_done_next = 1'b1;
                    end

                    if (chk_final) begin
                        state_next = ST_IDLE;
                    end else begin
                        ram_rd_en    = 1'b1;
                        chk_idx_next = chk_idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            filled_reg     <= '0;
            pend_valid_reg <= 1'b0;
            pend_done_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            filled_reg     <= filled_next;
            pend_valid_reg <= pend_valid_next;
            pend_done_reg  <= pend_done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        chk_idx_reg <= chk_idx_next;
        now_reg     <= now_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
    end

    // Result channel.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_reg.slot);
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule

`default_nettype wire

[sv/pts_ram.sv]
// ----------------------------------------------------------------------------
// pts_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_ram #(
    parameter  int WIDTH  = 64,
    parameter  int DEPTH  = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire               clk,
    input  wire               wr_en,
    input  wire  [ADDR_W-1:0] wr_addr,
    input  wire  [WIDTH-1:0]  wr_data,
    input  wire               rd_en,
    input  wire  [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; the data holds while no read is issued.
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[sv/pts_checker.sv]
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks of the periodic task scheduler, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "periodic_task_scheduler_assert.svh"

module pts_checker (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           s_tvalid,
    input wire                           s_tready,
    input wire                           m_tvalid,
    input wire                           m_tready,
    input wire [pts_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire [pts_pkg::KIND_W-1:0]     m_tuser,
    input wire                           m_tlast
);

    import pts_pkg::*;

    logic m_stalled;
    logic m_solo_kind;
    logic s_taken;

    assign m_stalled   = m_tvalid && !m_tready;
    assign m_solo_kind = (m_tuser == KIND_ADDED) || (m_tuser == KIND_FULL)
                      || (m_tuser == KIND_IDLE);
    assign s_taken     = s_tvalid && s_tready;

    // A stalled result word holds its content.
    `PTS_ASSERT_RUN(a_out_hold, aclk, aresetn, m_stalled |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result word changed while stalled")

    // Only fired words may continue a command; every other kind ends it.
    `PTS_ASSERT_RUN(a_solo_last, aclk, aresetn, m_tvalid && m_solo_kind |-> m_tlast, "single-word result without tlast")

    // Rejected adds and idle ticks report slot zero.
    `PTS_ASSERT_RUN(a_slot_zero, aclk, aresetn, m_tvalid && ((m_tuser == KIND_FULL) || (m_tuser == KIND_IDLE)) |-> (m_tdata == '0), "nonzero slot on a slotless result")

    // A taken command keeps the block busy for at least the next cycle.
    `PTS_ASSERT_RUN(a_busy_after_take, aclk, aresetn, s_taken |=> !s_tready, "command taken on two consecutive edges")

    // Reset drops any word in flight.
    `PTS_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> !m_tvalid, "result word valid right after reset")

endmodule

bind periodic_task_scheduler pts_checker u_pts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
